>>> design/cst_pkg.sv
// shared types, constants and helper functions for the c subset tokenizer
// no dependencies; all design files but cst_if refer to this package by scoped names
package cst_pkg;

  // result queue sizing, depth is a power of two
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  // token kinds
  localparam logic [3:0] TokInt    = 4'd0;
  localparam logic [3:0] TokReturn = 4'd1;
  localparam logic [3:0] TokVoid   = 4'd2;
  localparam logic [3:0] TokIdent  = 4'd3;
  localparam logic [3:0] TokLit    = 4'd4;
  localparam logic [3:0] TokLParen = 4'd5;
  localparam logic [3:0] TokRParen = 4'd6;
  localparam logic [3:0] TokLCurly = 4'd7;
  localparam logic [3:0] TokRCurly = 4'd8;
  localparam logic [3:0] TokSemi   = 4'd9;
  localparam logic [3:0] TokMinus  = 4'd10;
  localparam logic [3:0] TokEof    = 4'd11;
  localparam logic [3:0] TokError  = 4'd12;

  // error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrPunct   = 2'd1;
  localparam logic [1:0] ErrUnknown = 2'd2;

  localparam logic [15:0] Max16 = 16'hFFFF;

  typedef struct packed {
    logic [3:0]         kind;
    logic [1:0]         err;
    logic [15:0]        line;
    logic [15:0]        column;
    logic [15:0]        length;
    logic signed [63:0] value;
    logic               last;
  } res_t;

  // zero, one or two results from one processed byte
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == Max16) ? Max16 : v + 16'd1;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  // keyword lengths: int, return, void
  function automatic logic [2:0] kw_len(input logic [1:0] idx);
    logic [2:0] len;
    unique case (idx)
      2'd0:    len = 3'd3;
      2'd1:    len = 3'd6;
      2'd2:    len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // keyword text by position
  function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (idx)
      2'd0: begin
        unique case (pos)
          3'd0:    ch = "i";
          3'd1:    ch = "n";
          3'd2:    ch = "t";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (pos)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "t";
          3'd3:    ch = "u";
          3'd4:    ch = "r";
          3'd5:    ch = "n";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (pos)
          3'd0:    ch = "v";
          3'd1:    ch = "o";
          3'd2:    ch = "i";
          3'd3:    ch = "d";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // drop keywords that no longer match at this position
  function automatic logic [2:0] kw_update(input logic [2:0] cands, input logic [15:0] run,
                                           input logic [7:0] c);
    logic [2:0] res;
    res = cands;
    for (int i = 0; i < 3; i++) begin
      if (run >= {13'd0, kw_len(2'(i))} || kw_char(2'(i), run[2:0]) != c) begin
        res[i] = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

>>> design/cst_if.sv
// handshake channels of the c subset tokenizer: source bytes in, tokens out
// depends on nothing but the port widths of the field list
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_source;

  modport source (output valid, output char_code, output end_of_source, input ready);
  modport sink (input valid, input char_code, input end_of_source, output ready);
endinterface

interface cst_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [1:0]         error_code;
  logic [15:0]        token_line;
  logic [15:0]        token_column;
  logic [15:0]        token_length;
  logic signed [63:0] literal_value;
  logic               last_of_item;

  modport source (output valid, output token_kind, output error_code, output token_line,
                  output token_column, output token_length, output literal_value,
                  output last_of_item, input ready);
  modport sink (input valid, input token_kind, input error_code, input token_line,
                input token_column, input token_length, input literal_value,
                input last_of_item, output ready);
endinterface

>>> design/c_subset_tokenizer_core.sv
// top level of the c subset tokenizer: input register, scanner, result queue
// depends on cst_pkg, cst_if, cst_step and cst_res_fifo
//
//  channel  dir  payload                                       transfer when
//  src_i    in   char_code, end_of_source                      valid && ready
//  res_o    out  token_kind, error_code, token_line/column/     valid && ready
//                length, literal_value, last_of_item
//
// one byte is taken per cycle unless the input register holds; it is scanned from
// the input register and its tokens reach res_o through the result queue
// a byte that closes a token and makes one of its own yields two tokens, which
// leave one at a time; the one-per-cycle drain while res_o is ready sets the rate
// the input register holds while the queue has fewer than two free entries
// reset puts the scanner at line 1, column 1 between tokens and empties the queue
module c_subset_tokenizer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  cst_in_if.sink    src_i,
  cst_out_if.source res_o
);

  logic                         in_v_q;
  logic [7:0]                   char_q;
  logic                         eos_q;
  logic                         step_en;
  logic                         pop;
  logic [cst_pkg::ResCntW-1:0]  res_count;
  cst_pkg::push_t               push;
  cst_pkg::res_t                head;

  // scan the held byte once the queue can take two tokens
  assign step_en     = in_v_q &&
                       (res_count <= cst_pkg::ResCntW'(cst_pkg::ResDepth - 2));
  assign src_i.ready = !in_v_q || step_en;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (src_i.ready) begin
      in_v_q <= src_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_i.valid && src_i.ready) begin
      char_q <= src_i.char_code;
      eos_q  <= src_i.end_of_source;
    end
  end

  cst_step u_step (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_en_i       (step_en),
    .char_code_i     (char_q),
    .end_of_source_i (eos_q),
    .push_o          (push)
  );

  cst_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .count_o (res_count),
    .head_o  (head)
  );

  // output transfer from the head of the queue
  assign res_o.valid         = (res_count != '0);
  assign pop                 = res_o.valid && res_o.ready;
  assign res_o.token_kind    = head.kind;
  assign res_o.error_code    = head.err;
  assign res_o.token_line    = head.line;
  assign res_o.token_column  = head.column;
  assign res_o.token_length  = head.length;
  assign res_o.literal_value = head.value;
  assign res_o.last_of_item  = head.last;

endmodule

>>> design/cst_step.sv
// scanner state and the per-byte token logic of the c subset tokenizer
// depends on cst_pkg for token codes, result types and character helpers
module cst_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_en_i,
  input  logic [7:0]      char_code_i,
  input  logic            end_of_source_i,
  output cst_pkg::push_t  push_o
);

  localparam logic [2:0] ModeIdle   = 3'd0;
  localparam logic [2:0] ModeIdent  = 3'd1;
  localparam logic [2:0] ModeNumber = 3'd2;
  localparam logic [2:0] ModeMinus  = 3'd3;
  localparam logic [2:0] ModeHalt   = 3'd4;
  localparam logic [2:0] ModeDone   = 3'd5;

  logic [2:0]  mode_q, mode_d;
  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic [15:0] start_q, start_d;
  logic [15:0] run_q, run_d;
  logic [2:0]  cands_q, cands_d;
  logic [63:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic        ovf_q, ovf_d;

  logic               fin;
  logic               ident_ch;
  logic [3:0]         digit;
  logic [67:0]        mac;
  logic               do_flush;
  logic               fl_v;
  logic               sec_v;
  cst_pkg::res_t      fl;
  cst_pkg::res_t      sec;
  logic [3:0]         ident_kind;
  logic signed [63:0] lit_value;

  assign fin      = end_of_source_i || (char_code_i == 8'd0);
  assign ident_ch = cst_pkg::is_alpha(char_code_i) || cst_pkg::is_digit(char_code_i) ||
                    (char_code_i == "_");
  assign digit    = char_code_i[3:0];

  // magnitude times ten plus digit, carry above bit 63 means overflow
  assign mac = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {64'd0, digit};

  // identifier or keyword kind of a pending run
  always_comb begin
    ident_kind = cst_pkg::TokIdent;
    for (int i = 2; i >= 0; i--) begin
      if (cands_q[i] && run_q == {13'd0, cst_pkg::kw_len(2'(i))}) begin
        ident_kind = 4'(i);
      end
    end
  end

  // saturated literal value of a pending number
  always_comb begin
    if (neg_q) begin
      lit_value = (ovf_q || mag_q > 64'h8000_0000_0000_0000) ?
                  64'sh8000_0000_0000_0000 : $signed(64'd0 - mag_q);
    end else begin
      lit_value = (ovf_q || mag_q[63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(mag_q);
    end
  end

  // pending token, emitted when the run ends
  always_comb begin
    fl        = '0;
    fl.line   = line_q;
    fl.column = start_q;
    fl.length = run_q;
    fl.err    = cst_pkg::ErrNone;
    fl.kind   = cst_pkg::TokIdent;
    unique case (mode_q)
      ModeIdent:  fl.kind = ident_kind;
      ModeNumber: begin
        fl.kind  = cst_pkg::TokLit;
        fl.value = lit_value;
      end
      ModeMinus:  begin
        fl.kind   = cst_pkg::TokMinus;
        fl.length = 16'd1;
      end
      default:    fl.kind = cst_pkg::TokIdent;
    endcase
  end

  // next state and the result that the byte itself makes
  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    start_d  = start_q;
    run_d    = run_q;
    cands_d  = cands_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    do_flush = 1'b0;
    sec_v    = 1'b0;
    sec      = '0;
    sec.line   = line_q;
    sec.column = col_q;
    sec.length = 16'd1;
    sec.err    = cst_pkg::ErrNone;
    sec.kind   = cst_pkg::TokEof;

    if (step_en_i && mode_q != ModeHalt && mode_q != ModeDone) begin
      if (fin) begin
        do_flush   = 1'b1;
        sec_v      = 1'b1;
        sec.kind   = cst_pkg::TokEof;
        sec.length = 16'd0;
        mode_d     = ModeDone;
      end else if (mode_q == ModeIdent && ident_ch) begin
        cands_d = cst_pkg::kw_update(cands_q, run_q, char_code_i);
        run_d   = cst_pkg::sat_inc16(run_q);
        col_d   = cst_pkg::sat_inc16(col_q);
      end else if ((mode_q == ModeNumber || mode_q == ModeMinus) &&
                   cst_pkg::is_digit(char_code_i)) begin
        if (mode_q == ModeMinus) begin
          mode_d = ModeNumber;
          neg_d  = 1'b1;
        end
        if (ovf_q || mac[67:64] != 4'd0) begin
          ovf_d = 1'b1;
        end else begin
          mag_d = mac[63:0];
        end
        run_d = cst_pkg::sat_inc16(run_q);
        col_d = cst_pkg::sat_inc16(col_q);
      end else begin
        do_flush = 1'b1;
        mode_d   = ModeIdle;
        if (char_code_i == 8'h20 || char_code_i == 8'h09 || char_code_i == 8'h0B ||
            char_code_i == 8'h0C || char_code_i == 8'h0D) begin
          col_d = cst_pkg::sat_inc16(col_q);
        end else if (char_code_i == 8'h0A) begin
          line_d = cst_pkg::sat_inc16(line_q);
          col_d  = 16'd1;
        end else if (cst_pkg::is_alpha(char_code_i) || char_code_i == "_") begin
          mode_d  = ModeIdent;
          start_d = col_q;
          run_d   = 16'd1;
          cands_d = cst_pkg::kw_update(3'b111, 16'd0, char_code_i);
          mag_d   = 64'd0;
          neg_d   = 1'b0;
          ovf_d   = 1'b0;
          col_d   = cst_pkg::sat_inc16(col_q);
        end else if (cst_pkg::is_digit(char_code_i)) begin
          mode_d  = ModeNumber;
          start_d = col_q;
          run_d   = 16'd1;
          cands_d = 3'b111;
          mag_d   = {60'd0, digit};
          neg_d   = 1'b0;
          ovf_d   = 1'b0;
          col_d   = cst_pkg::sat_inc16(col_q);
        end else if (char_code_i == "-") begin
          mode_d  = ModeMinus;
          start_d = col_q;
          run_d   = 16'd1;
          cands_d = 3'b111;
          mag_d   = 64'd0;
          neg_d   = 1'b0;
          ovf_d   = 1'b0;
          col_d   = cst_pkg::sat_inc16(col_q);
        end else begin
          sec_v = 1'b1;
          case (char_code_i)
            "(":     sec.kind = cst_pkg::TokLParen;
            ")":     sec.kind = cst_pkg::TokRParen;
            "{":     sec.kind = cst_pkg::TokLCurly;
            "}":     sec.kind = cst_pkg::TokRCurly;
            ";":     sec.kind = cst_pkg::TokSemi;
            default: sec.kind = cst_pkg::TokError;
          endcase
          if (sec.kind == cst_pkg::TokError) begin
            sec.err = cst_pkg::is_punct(char_code_i) ? cst_pkg::ErrPunct : cst_pkg::ErrUnknown;
            mode_d  = ModeHalt;
          end else begin
            col_d = cst_pkg::sat_inc16(col_q);
          end
        end
      end
    end
  end

  assign fl_v = do_flush && (mode_q == ModeIdent || mode_q == ModeNumber ||
                             mode_q == ModeMinus);

  // order the results and mark the last one of the byte
  always_comb begin
    push_o.count  = {1'b0, fl_v} + {1'b0, sec_v};
    push_o.second = sec;
    push_o.second.last = 1'b1;
    push_o.first  = fl_v ? fl : sec;
    push_o.first.last = !(fl_v && sec_v);
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      line_q  <= 16'd1;
      col_q   <= 16'd1;
      start_q <= 16'd1;
      run_q   <= 16'd0;
      cands_q <= 3'b111;
      mag_q   <= 64'd0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      start_q <= start_d;
      run_q   <= run_d;
      cands_q <= cands_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

>>> design/cst_res_fifo.sv
// small result queue that takes up to two tokens a cycle and hands out one
// depends on cst_pkg for the result types and the queue depth
module cst_res_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cst_pkg::push_t               push_i,
  input  logic                         pop_i,
  output logic [cst_pkg::ResCntW-1:0]  count_o,
  output cst_pkg::res_t                head_o
);

  cst_pkg::res_t                mem_q [cst_pkg::ResDepth];
  logic [cst_pkg::ResPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [cst_pkg::ResPtrW-1:0]  wr_ptr_nxt;
  logic [cst_pkg::ResCntW-1:0]  count_q;

  assign wr_ptr_nxt = wr_ptr_q + cst_pkg::ResPtrW'(1);
  assign count_o    = count_q;
  assign head_o     = mem_q[rd_ptr_q];

  // storage, one or two entries written per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + cst_pkg::ResPtrW'(push_i.count);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + cst_pkg::ResPtrW'(1);
      end
      count_q <= count_q + cst_pkg::ResCntW'(push_i.count) - cst_pkg::ResCntW'(pop_i);
    end
  end

endmodule

>>> sim/c_subset_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// self-checking bench for c_subset_tokenizer_core: bytes go in, each token is compared
// in order with a scanner model here or a typed row; uses cst_pkg, cst_if and the design
module c_subset_tokenizer_core_tb;

  localparam int unsigned   CycleLimit  = 1000000;
  localparam int unsigned   RandomBytes = 1700;
  localparam int unsigned   DrainCycles = 20;
  localparam int unsigned   PrintCap    = 100;
  localparam cst_pkg::res_t NoTok       = '0;

  typedef enum logic [2:0] {
    ScanIdle,
    ScanIdent,
    ScanNumber,
    ScanMinus,
    ScanHalted,
    ScanDone
  } scan_mode_e;

  typedef struct packed {
    logic [7:0]    ch;
    logic          typed;
    cst_pkg::res_t tok;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cst_in_if  src_if ();
  cst_out_if res_if ();

  c_subset_tokenizer_core u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .src_i (src_if),
    .res_o (res_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner model state
  scan_mode_e  sc_mode;
  logic [15:0] sc_line;
  logic [15:0] sc_col;
  logic [15:0] sc_start;
  logic [15:0] sc_run;
  logic [2:0]  sc_kw;
  logic [63:0] sc_mag;
  logic        sc_neg;
  logic        sc_ovf;

  cst_pkg::res_t new_tokens[$];
  cst_pkg::res_t pending_tokens[$];
  logic [7:0]    lexeme_q[$];

  int  mismatch_count = 0;
  int  tokens_seen = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;

  // short directed stream, typed tokens where they are obvious
  stim_row_t dir_rows [25] = '{
    '{"(", 1'b1, '{cst_pkg::TokLParen, cst_pkg::ErrNone, 16'd1, 16'd1, 16'd1, 64'sd0, 1'b1}},
    '{")", 1'b1, '{cst_pkg::TokRParen, cst_pkg::ErrNone, 16'd1, 16'd2, 16'd1, 64'sd0, 1'b1}},
    '{"i", 1'b0, NoTok},
    '{"n", 1'b0, NoTok},
    '{"t", 1'b0, NoTok},
    '{8'h0A, 1'b1, '{cst_pkg::TokInt, cst_pkg::ErrNone, 16'd1, 16'd3, 16'd3, 64'sd0, 1'b1}},
    '{"-", 1'b0, NoTok},
    '{"7", 1'b0, NoTok},
    '{";", 1'b0, NoTok},
    '{"-", 1'b0, NoTok},
    '{8'h0B, 1'b0, NoTok},
    '{"v", 1'b0, NoTok},
    '{"o", 1'b0, NoTok},
    '{"i", 1'b0, NoTok},
    '{"d", 1'b0, NoTok},
    '{"{", 1'b0, NoTok},
    '{"}", 1'b0, NoTok},
    '{8'h0C, 1'b0, NoTok},
    '{"r", 1'b0, NoTok},
    '{"e", 1'b0, NoTok},
    '{"t", 1'b0, NoTok},
    '{"u", 1'b0, NoTok},
    '{"r", 1'b0, NoTok},
    '{"n", 1'b0, NoTok},
    '{";", 1'b0, NoTok}
  };

  // character classes
  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || is_num(c) || c == "_";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  // bytes that keep the scanner running
  function automatic logic is_legal(input logic [7:0] c);
    return is_word(c) || is_blank(c) || c == 8'h0A || c == "-" || c == "(" ||
           c == ")" || c == "{" || c == "}" || c == ";";
  endfunction

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // keyword table: int, return, void
  function automatic int kw_length(input int idx);
    case (idx)
      0:       return 3;
      1:       return 6;
      default: return 4;
    endcase
  endfunction

  function automatic logic [7:0] kw_letter(input int idx, input int pos);
    logic [47:0] txt;
    case (idx)
      0:       txt = "int";
      1:       txt = "return";
      default: txt = "void";
    endcase
    return txt[8 * (kw_length(idx) - 1 - pos) +: 8];
  endfunction

  function automatic logic [3:0] kw_token(input int idx);
    case (idx)
      0:       return cst_pkg::TokInt;
      1:       return cst_pkg::TokReturn;
      default: return cst_pkg::TokVoid;
    endcase
  endfunction

  task automatic emit(input logic [3:0] kind, input logic [1:0] err, input logic [15:0] col,
                      input logic [15:0] len, input logic [63:0] val);
    cst_pkg::res_t t;
    t.kind   = kind;
    t.err    = err;
    t.line   = sc_line;
    t.column = col;
    t.length = len;
    t.value  = val;
    t.last   = 1'b0;
    new_tokens.push_back(t);
  endtask

  task automatic open_token(input scan_mode_e mode);
    sc_mode  = mode;
    sc_start = sc_col;
    sc_run   = 16'd0;
    sc_kw    = 3'b111;
    sc_mag   = 64'd0;
    sc_neg   = 1'b0;
    sc_ovf   = 1'b0;
  endtask

  task automatic reset_scanner();
    sc_line = 16'd1;
    sc_col  = 16'd1;
    open_token(ScanIdle);
    sc_start = 16'd1;
  endtask

  task automatic match_keywords(input logic [7:0] c);
    int i;
    for (i = 0; i < 3; i++) begin
      if (sc_run >= 16'(kw_length(i))) begin
        sc_kw[i] = 1'b0;
      end else if (kw_letter(i, int'(sc_run)) != c) begin
        sc_kw[i] = 1'b0;
      end
    end
  endtask

  // decimal accumulate, sticky overflow past 64 unsigned bits
  task automatic accumulate_digit(input logic [3:0] d);
    if (sc_ovf || sc_mag > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10) begin
      sc_ovf = 1'b1;
    end else begin
      sc_mag = sc_mag * 64'd10 + 64'(d);
    end
  endtask

  // emit whatever token is open and go idle
  task automatic close_token();
    logic [3:0]  kind;
    logic [63:0] v;
    int          i;
    if (sc_mode == ScanIdent) begin
      kind = cst_pkg::TokIdent;
      for (i = 0; i < 3; i++) begin
        if (sc_kw[i] && sc_run == 16'(kw_length(i))) kind = kw_token(i);
      end
      emit(kind, cst_pkg::ErrNone, sc_start, sc_run, 64'd0);
    end else if (sc_mode == ScanNumber) begin
      if (sc_neg) begin
        v = (sc_ovf || sc_mag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                                           : 64'd0 - sc_mag;
      end else begin
        v = (sc_ovf || sc_mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : sc_mag;
      end
      emit(cst_pkg::TokLit, cst_pkg::ErrNone, sc_start, sc_run, v);
    end else if (sc_mode == ScanMinus) begin
      emit(cst_pkg::TokMinus, cst_pkg::ErrNone, sc_start, 16'd1, 64'd0);
    end
    sc_mode = ScanIdle;
  endtask

  // byte seen between tokens
  task automatic take_idle_byte(input logic [7:0] c);
    logic [3:0] kind;
    kind = cst_pkg::TokError;
    if (is_blank(c)) begin
      sc_col = bump16(sc_col);
    end else if (c == 8'h0A) begin
      sc_line = bump16(sc_line);
      sc_col  = 16'd1;
    end else if (is_letter(c) || c == "_") begin
      open_token(ScanIdent);
      match_keywords(c);
      sc_run = 16'd1;
      sc_col = bump16(sc_col);
    end else if (is_num(c)) begin
      open_token(ScanNumber);
      accumulate_digit(4'(c - 8'h30));
      sc_run = 16'd1;
      sc_col = bump16(sc_col);
    end else if (c == "-") begin
      open_token(ScanMinus);
      sc_run = 16'd1;
      sc_col = bump16(sc_col);
    end else begin
      case (c)
        "(":     kind = cst_pkg::TokLParen;
        ")":     kind = cst_pkg::TokRParen;
        "{":     kind = cst_pkg::TokLCurly;
        "}":     kind = cst_pkg::TokRCurly;
        ";":     kind = cst_pkg::TokSemi;
        default: kind = cst_pkg::TokError;
      endcase
      if (kind != cst_pkg::TokError) begin
        emit(kind, cst_pkg::ErrNone, sc_col, 16'd1, 64'd0);
        sc_col = bump16(sc_col);
      end else begin
        emit(cst_pkg::TokError, is_sym(c) ? cst_pkg::ErrPunct : cst_pkg::ErrUnknown,
             sc_col, 16'd1, 64'd0);
        sc_mode = ScanHalted;
      end
    end
  endtask

  // tokens caused by one accepted byte, left in new_tokens
  task automatic scan_byte(input logic [7:0] c, input logic eos);
    logic fin;
    fin = eos || (c == 8'h00);
    new_tokens.delete();
    if (sc_mode == ScanHalted || sc_mode == ScanDone) return;
    if (fin) begin
      close_token();
      emit(cst_pkg::TokEof, cst_pkg::ErrNone, sc_col, 16'd0, 64'd0);
      sc_mode = ScanDone;
    end else if (sc_mode == ScanIdent && is_word(c)) begin
      match_keywords(c);
      sc_run = bump16(sc_run);
      sc_col = bump16(sc_col);
    end else if ((sc_mode == ScanNumber || sc_mode == ScanMinus) && is_num(c)) begin
      if (sc_mode == ScanMinus) begin
        sc_mode = ScanNumber;
        sc_neg  = 1'b1;
      end
      accumulate_digit(4'(c - 8'h30));
      sc_run = bump16(sc_run);
      sc_col = bump16(sc_col);
    end else begin
      close_token();
      take_idle_byte(c);
    end
    if (new_tokens.size() > 0) new_tokens[new_tokens.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PrintCap) begin
      $display("token %0d: %s got %0h want %0h", tokens_seen, what, got, want);
    end
  endtask

  // one byte transfer on the source channel, then the model runs on it
  task automatic send_byte(input logic [7:0] c, input logic eos, input logic typed,
                           input cst_pkg::res_t typed_tok);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_if.valid         <= 1'b1;
    src_if.char_code     <= c;
    src_if.end_of_source <= eos;
    do @(posedge clk); while (src_if.ready !== 1'b1);
    scan_byte(c, eos);
    if (typed) begin
      pending_tokens.push_back(typed_tok);
    end else begin
      foreach (new_tokens[i]) pending_tokens.push_back(new_tokens[i]);
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) lexeme_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return 8'h0A;
    endcase
  endfunction

  // one well-formed lexeme with random content, sometimes glued to the next one
  task automatic make_lexeme();
    int pick;
    int n;
    lexeme_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      case ($urandom_range(0, 2))
        0:       push_text("int");
        1:       push_text("return");
        default: push_text("void");
      endcase
      // near misses: cut short, extended, wrong case
      case ($urandom_range(0, 5))
        0:       void'(lexeme_q.pop_back());
        1:       lexeme_q.push_back(rand_word_char());
        2:       lexeme_q[0] = lexeme_q[0] - 8'h20;
        default: ;
      endcase
    end else if (pick < 40) begin
      n = $urandom_range(0, 52);
      lexeme_q.push_back(n < 26 ? 8'("a" + n) : n < 52 ? 8'("A" + n - 26) : 8'("_"));
      n = $urandom_range(0, 11);
      repeat (n) lexeme_q.push_back(rand_word_char());
    end else if (pick < 60) begin
      if ($urandom_range(0, 2) == 0) lexeme_q.push_back("-");
      if ($urandom_range(0, 4) == 0) begin
        // values around the signed 64-bit limits
        case ($urandom_range(0, 6))
          0:       push_text("9223372036854775807");
          1:       push_text("9223372036854775808");
          2:       push_text("9223372036854775809");
          3:       push_text("18446744073709551615");
          4:       push_text("18446744073709551616");
          5:       push_text("0000000000000000000000000009");
          default: push_text("999999999999999999999999");
        endcase
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) lexeme_q.push_back(8'("0" + $urandom_range(0, 9)));
      end
    end else if (pick < 70) begin
      lexeme_q.push_back("-");
    end else if (pick < 85) begin
      case ($urandom_range(0, 4))
        0:       lexeme_q.push_back("(");
        1:       lexeme_q.push_back(")");
        2:       lexeme_q.push_back("{");
        3:       lexeme_q.push_back("}");
        default: lexeme_q.push_back(";");
      endcase
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) lexeme_q.push_back(rand_blank());
    end
    if ($urandom_range(0, 1) == 1) lexeme_q.push_back(rand_blank());
  endtask

  task automatic send_lexemes(input int count);
    repeat (count) begin
      make_lexeme();
      foreach (lexeme_q[i]) send_byte(lexeme_q[i], 1'b0, 1'b0, NoTok);
    end
  endtask

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, each transfer checked against the oldest expected token
  initial begin : token_sink
    int            stall;
    cst_pkg::res_t want;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        report_mismatch("unexpected token, kind", 64'(res_if.token_kind), 64'd0);
      end else begin
        want = pending_tokens.pop_front();
        if (res_if.token_kind !== want.kind)
          report_mismatch("kind", 64'(res_if.token_kind), 64'(want.kind));
        if (res_if.error_code !== want.err)
          report_mismatch("error code", 64'(res_if.error_code), 64'(want.err));
        if (res_if.token_line !== want.line)
          report_mismatch("line", 64'(res_if.token_line), 64'(want.line));
        if (res_if.token_column !== want.column)
          report_mismatch("column", 64'(res_if.token_column), 64'(want.column));
        if (res_if.token_length !== want.length)
          report_mismatch("length", 64'(res_if.token_length), 64'(want.length));
        if (res_if.literal_value !== want.value)
          report_mismatch("value", res_if.literal_value, want.value);
        if (res_if.last_of_item !== want.last)
          report_mismatch("last flag", 64'(res_if.last_of_item), 64'(want.last));
      end
    end
  end

  // source side: directed rows, random lexemes, then a terminator
  initial begin : byte_source
    int         random_sent;
    int         sel;
    bit         paused;
    logic [7:0] c;
    random_sent = 0;
    paused      = 1'b0;
    src_if.valid         <= 1'b0;
    src_if.char_code     <= 8'h00;
    src_if.end_of_source <= 1'b0;
    reset_scanner();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, 1'b0, dir_rows[i].typed, dir_rows[i].tok);

    while (random_sent < RandomBytes) begin
      if ($urandom_range(0, 99) < 3) no_idle = !no_idle;
      // one hold-off until the result side has caught up
      if (!paused && random_sent >= RandomBytes / 2) begin
        paused = 1'b1;
        src_if.valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
      end
      make_lexeme();
      foreach (lexeme_q[i]) send_byte(lexeme_q[i], 1'b0, 1'b0, NoTok);
      random_sent += lexeme_q.size();
    end

    send_lexemes(40);

    // maybe leave a token open, then end of source or an error byte
    if ($urandom_range(0, 1) == 1) begin
      make_lexeme();
      while (lexeme_q.size() > 1 && !is_legal(lexeme_q[lexeme_q.size() - 1])) begin
        void'(lexeme_q.pop_back());
      end
      foreach (lexeme_q[i]) send_byte(lexeme_q[i], 1'b0, 1'b0, NoTok);
    end
    sel = $urandom_range(0, 3);
    case (sel)
      0: send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NoTok);
      1: send_byte(8'h00, 1'b0, 1'b0, NoTok);
      2: begin
        do c = 8'($urandom_range(33, 126)); while (!is_sym(c) || is_legal(c));
        send_byte(c, 1'b0, 1'b0, NoTok);
      end
      default: begin
        do c = 8'($urandom_range(1, 255)); while (is_sym(c) || is_legal(c));
        send_byte(c, 1'b0, 1'b0, NoTok);
      end
    endcase

    // everything after the terminator is dropped by the block
    repeat (8) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, NoTok);

    src_if.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
